// File: hdl/bss_pkg.sv
`timescale 1ns / 1ps

package bss_pkg;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    logic [1:0] func;
    coord_t     a_x;
    coord_t     a_y;
    coord_t     a_z;
    coord_t     b_x;
    coord_t     b_y;
    coord_t     b_z;
    coord_t     c_x;
    coord_t     c_y;
    coord_t     c_z;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  split_axis;
    coord_t      split_position;
    logic [62:0] best_cost;
    logic        side;
    coord_t      box_min_x;
    coord_t      box_min_y;
    coord_t      box_min_z;
    coord_t      box_max_x;
    coord_t      box_max_y;
    coord_t      box_max_z;
    logic        last;
  } out_item_t;

  // Index 0 is x, 1 is y, 2 is z.
  typedef struct packed {
    logic [2:0][31:0] lo;
    logic [2:0][31:0] hi;
  } box_t;

  localparam logic [1:0] FUNC_BEGIN  = 2'd0;
  localparam logic [1:0] FUNC_TRI    = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [5:0]  BINS_RESET = 6'd16;
  localparam logic [62:0] COST_TOP   = {63{1'b1}};
  localparam int          AREA_W     = 51;
  localparam int          DEN_W      = 42;
  localparam int          SCALE_FRAC = 26;

  localparam box_t EMPTY_BOX = '{lo: {3{32'h7FFF_FFFF}}, hi: {3{32'h8000_0000}}};

  typedef struct packed {
    logic ld_begin;
    logic div_begin;
    logic clr_wr;
    logic ld_tri;
    logic tri_mul;
    logic tri_rd;
    logic tri_wr;
    logic fin_init;
    logic pfx_rd;
    logic pfx_wr;
    logic scan_rd;
    logic scan_grow;
    logic area_step;
    logic cmul_step;
    logic eval;
    logic pos_start;
    logic out_side;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_top;
    logic idx_zero;
    logic clr_last;
    logic area_last;
    logic cmul_last;
    logic div_busy;
    logic div_done;
    logic found;
  } dp_status_t;

  function automatic box_t box_grow(box_t b, box_t x);
    box_t r;
    r = b;
    for (int k = 0; k < 3; k++) begin
      if ($signed(x.lo[k]) < $signed(r.lo[k])) r.lo[k] = x.lo[k];
      if ($signed(x.hi[k]) > $signed(r.hi[k])) r.hi[k] = x.hi[k];
    end
    return r;
  endfunction

endpackage

// File: hdl/bss_divider.sv
`timescale 1ns / 1ps

module bss_divider #(
  parameter int NW = 42,
  parameter int DW = 42
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW:0]     rem_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   den_q;
  logic [DW:0]     trial;
  logic            ge;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_q[DW-1:0], quo_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial - {1'b0, den_q} : trial;
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: hdl/bss_controller.sv
`timescale 1ns / 1ps

module bss_controller
  import bss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_func_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t st_i
);

  typedef enum logic [18:0] {
    S_CLEAR     = 19'h00001,
    S_DIV_WAIT  = 19'h00002,
    S_IDLE      = 19'h00004,
    S_BEGIN     = 19'h00008,
    S_TRI_MUL   = 19'h00010,
    S_TRI_RD    = 19'h00020,
    S_TRI_WR    = 19'h00040,
    S_PFX_RD    = 19'h00080,
    S_PFX_WR    = 19'h00100,
    S_SCAN_RD   = 19'h00200,
    S_SCAN_GROW = 19'h00400,
    S_AREA      = 19'h00800,
    S_CMUL      = 19'h01000,
    S_EVAL      = 19'h02000,
    S_SCAN_END  = 19'h04000,
    S_POS_GO    = 19'h08000,
    S_POS_WAIT  = 19'h10000,
    S_OUT_L     = 19'h20000,
    S_OUT_R     = 19'h40000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (st_i.clr_last) state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!st_i.div_busy) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_func_i)
            FUNC_BEGIN: begin
              cmd_o.ld_begin = 1'b1;
              state_d        = S_BEGIN;
            end
            FUNC_TRI: begin
              cmd_o.ld_tri = 1'b1;
              state_d      = S_TRI_MUL;
            end
            FUNC_FINISH: begin
              cmd_o.fin_init = 1'b1;
              state_d        = S_PFX_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_BEGIN: begin
        cmd_o.div_begin = 1'b1;
        state_d         = S_CLEAR;
      end
      S_TRI_MUL: begin
        cmd_o.tri_mul = 1'b1;
        state_d       = S_TRI_RD;
      end
      S_TRI_RD: begin
        cmd_o.tri_rd = 1'b1;
        state_d      = S_TRI_WR;
      end
      S_TRI_WR: begin
        cmd_o.tri_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_PFX_RD: begin
        cmd_o.pfx_rd = 1'b1;
        state_d      = S_PFX_WR;
      end
      S_PFX_WR: begin
        cmd_o.pfx_wr = 1'b1;
        state_d      = st_i.idx_top ? S_SCAN_RD : S_PFX_RD;
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN_GROW;
      end
      S_SCAN_GROW: begin
        cmd_o.scan_grow = 1'b1;
        state_d         = S_AREA;
      end
      S_AREA: begin
        cmd_o.area_step = 1'b1;
        if (st_i.area_last) state_d = S_CMUL;
      end
      S_CMUL: begin
        cmd_o.cmul_step = 1'b1;
        if (st_i.cmul_last) state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = st_i.idx_zero ? S_SCAN_END : S_SCAN_RD;
      end
      S_SCAN_END: begin
        state_d = st_i.found ? S_POS_GO : S_OUT_L;
      end
      S_POS_GO: begin
        cmd_o.pos_start = 1'b1;
        state_d         = S_POS_WAIT;
      end
      S_POS_WAIT: begin
        if (st_i.div_done) state_d = S_OUT_L;
      end
      S_OUT_L: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_OUT_R;
      end
      S_OUT_R: begin
        out_valid_o    = 1'b1;
        cmd_o.out_side = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

// File: hdl/bss_datapath.sv
`timescale 1ns / 1ps

module bss_datapath
  import bss_pkg::*;
#(
  parameter int MAX_BINS   = 32,
  parameter int COUNT_BITS = 21
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_data_i,
  input  logic       cfg_valid_i,
  input  logic [5:0] cfg_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t st_o,
  output out_item_t  out_data_o
);

  localparam int IW     = $clog2(MAX_BINS);
  localparam int NB     = $clog2(MAX_BINS + 1);
  localparam int CW     = COUNT_BITS + IW;
  localparam int PW     = (AREA_W + CW > 64) ? AREA_W + CW : 64;
  localparam int DIV_NW = NB + 36;
  localparam int CMW    = $clog2(CW + 1);

  typedef struct packed {
    box_t                  bx;
    logic [COUNT_BITS-1:0] cnt;
  } bin_ent_t;

  typedef struct packed {
    box_t          bx;
    logic [CW-1:0] cnt;
  } pfx_ent_t;

  // Configuration and per-node setup.
  logic [5:0]  bins_q;
  logic [1:0]  axis_q;
  logic [31:0] origin_q, extent_q, scale_q, pos_q;
  logic [NB-1:0] n_w;

  always_comb begin
    if (bins_q < 6'd2) n_w = NB'(2);
    else if (32'(bins_q) > 32'(MAX_BINS)) n_w = NB'(MAX_BINS);
    else n_w = NB'(bins_q);
  end

  logic [IW-1:0] nm1, nm2;
  assign nm1 = IW'(n_w - NB'(1));
  assign nm2 = IW'(n_w - NB'(2));

  // Longest axis of the begin bounds.
  logic signed [32:0] sz [3];
  logic [1:0]         axis_d;
  logic [31:0]        origin_d;
  logic signed [32:0] sz_sel;

  always_comb begin
    sz[0] = 33'(in_data_i.b_x) - 33'(in_data_i.a_x);
    sz[1] = 33'(in_data_i.b_y) - 33'(in_data_i.a_y);
    sz[2] = 33'(in_data_i.b_z) - 33'(in_data_i.a_z);
    sz[0] = $signed({in_data_i.b_x[31], in_data_i.b_x})
          - $signed({in_data_i.a_x[31], in_data_i.a_x});
    sz[1] = $signed({in_data_i.b_y[31], in_data_i.b_y})
          - $signed({in_data_i.a_y[31], in_data_i.a_y});
    sz[2] = $signed({in_data_i.b_z[31], in_data_i.b_z})
          - $signed({in_data_i.a_z[31], in_data_i.a_z});
    if (sz[0] >= sz[1] && sz[0] >= sz[2]) begin
      axis_d   = AXIS_X;
      origin_d = in_data_i.a_x;
      sz_sel   = sz[0];
    end else if (sz[1] >= sz[2]) begin
      axis_d   = AXIS_Y;
      origin_d = in_data_i.a_y;
      sz_sel   = sz[1];
    end else begin
      axis_d   = AXIS_Z;
      origin_d = in_data_i.a_z;
      sz_sel   = sz[2];
    end
  end

  // Divider shared by the bin scale and the split position.
  logic              div_start, div_busy, div_done, div_pos_q;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DEN_W-1:0]  div_den;
  logic [NB+9:0]     n999;
  logic [IW-1:0]     best_idx_q;

  assign n999      = (NB + 10)'(n_w) * (NB + 10)'(999);
  assign div_start = (cmd_i.div_begin && extent_q != '0) || cmd_i.pos_start;

  always_comb begin
    if (cmd_i.pos_start) begin
      div_num = DIV_NW'(extent_q) * DIV_NW'(NB'(best_idx_q) + NB'(1));
      div_den = DEN_W'(n_w);
    end else begin
      div_num = DIV_NW'({n999, {SCALE_FRAC{1'b0}}});
      div_den = DEN_W'(extent_q) * DEN_W'(1000);
    end
  end

  bss_divider #(
    .NW(DIV_NW),
    .DW(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Shared 32 x 32 multiplier.
  in_item_t           tri_q;
  box_t               lbox_q, racc_q, acc_q, best_l_q, best_r_q;
  logic [2:0]         ak_q;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod_q;
  logic [31:0]        dl [3];
  logic [31:0]        dr [3];
  logic               empty_l, empty_r;
  logic signed [32:0] tri_d;
  logic [31:0]        tri_c;

  always_comb begin
    case (axis_q)
      AXIS_Y:  tri_c = tri_q.c_y;
      AXIS_Z:  tri_c = tri_q.c_z;
      default: tri_c = tri_q.c_x;
    endcase
    tri_d   = $signed({tri_c[31], tri_c}) - $signed({origin_q[31], origin_q});
    empty_l = 1'b0;
    empty_r = 1'b0;
    for (int k = 0; k < 3; k++) begin
      dl[k] = lbox_q.hi[k] - lbox_q.lo[k];
      dr[k] = racc_q.hi[k] - racc_q.lo[k];
      if ($signed(lbox_q.lo[k]) > $signed(lbox_q.hi[k])) empty_l = 1'b1;
      if ($signed(racc_q.lo[k]) > $signed(racc_q.hi[k])) empty_r = 1'b1;
    end
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.tri_mul) begin
      if (!tri_d[32] && tri_d != '0) mul_a = tri_d[31:0];
      mul_b = scale_q;
    end else begin
      case (ak_q)
        3'd0: begin mul_a = dl[0]; mul_b = dl[1]; end
        3'd1: begin mul_a = dl[1]; mul_b = dl[2]; end
        3'd2: begin mul_a = dl[2]; mul_b = dl[0]; end
        3'd3: begin mul_a = dr[0]; mul_b = dr[1]; end
        3'd4: begin mul_a = dr[1]; mul_b = dr[2]; end
        3'd5: begin mul_a = dr[2]; mul_b = dr[0]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // Bin index from the registered product, clamped to the last bin.
  logic [37:0]   idx_raw;
  logic [IW-1:0] tri_idx, tri_idx_q;
  assign idx_raw = prod_q[63:SCALE_FRAC];
  assign tri_idx = (idx_raw > 38'(nm1)) ? nm1 : IW'(idx_raw);

  // Bin memory and prefix memory.
  bin_ent_t      bin_mem [MAX_BINS];
  pfx_ent_t      pfx_mem [MAX_BINS];
  bin_ent_t      brd_q, bin_wdata;
  pfx_ent_t      prd_q, pfx_wdata;
  logic [IW-1:0] idx_q, bin_raddr, bin_waddr;
  logic          bin_we;
  box_t          acc_next;
  logic [CW-1:0] lcnt_q, nr_q, lcnt_next;

  always_comb begin
    if (cmd_i.tri_rd) bin_raddr = tri_idx;
    else if (cmd_i.scan_rd) bin_raddr = idx_q + IW'(1);
    else bin_raddr = idx_q;
    bin_we    = cmd_i.clr_wr || cmd_i.tri_wr;
    bin_waddr = cmd_i.tri_wr ? tri_idx_q : idx_q;
    if (cmd_i.tri_wr) begin
      bin_wdata.bx  = box_grow(brd_q.bx, '{lo: {tri_q.a_z, tri_q.a_y, tri_q.a_x},
                                         hi: {tri_q.b_z, tri_q.b_y, tri_q.b_x}});
      bin_wdata.cnt = (&brd_q.cnt) ? brd_q.cnt : brd_q.cnt + 1'b1;
    end else begin
      bin_wdata.bx  = EMPTY_BOX;
      bin_wdata.cnt = '0;
    end
    acc_next      = box_grow(acc_q, brd_q.bx);
    lcnt_next     = lcnt_q + CW'(brd_q.cnt);
    pfx_wdata.bx  = acc_next;
    pfx_wdata.cnt = lcnt_next;
  end

  always_ff @(posedge clk_i) begin
    if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
    brd_q <= bin_mem[bin_raddr];
    if (cmd_i.pfx_wr) pfx_mem[idx_q] <= pfx_wdata;
    prd_q <= pfx_mem[idx_q];
  end

  // Area accumulation and serial count times area products.
  logic [AREA_W-2:0] sum_l_q, sum_r_q;
  logic [AREA_W-1:0] area_l, area_r;
  logic [PW-1:0]     acc_l_q, acc_r_q;
  logic [CW-1:0]     ml_q, mr_q;
  logic [CMW-1:0]    cm_q;
  logic [62:0]       sat_l, sat_r, best_q, cost;
  logic [63:0]       cost_sum;
  logic              found_q, cost_ok;

  assign area_l   = empty_l ? '0 : {sum_l_q, 1'b0};
  assign area_r   = empty_r ? '0 : {sum_r_q, 1'b0};
  assign sat_l    = (acc_l_q > PW'(COST_TOP)) ? COST_TOP : acc_l_q[62:0];
  assign sat_r    = (acc_r_q > PW'(COST_TOP)) ? COST_TOP : acc_r_q[62:0];
  assign cost_sum = {1'b0, sat_l} + {1'b0, sat_r};
  assign cost     = (cost_sum > {1'b0, COST_TOP}) ? COST_TOP : cost_sum[62:0];
  // Equal cost keeps the earlier hit, which is the higher plane.
  assign cost_ok  = cost != '0 && (!found_q || cost < best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q    <= BINS_RESET;
      axis_q    <= AXIS_X;
      origin_q  <= '0;
      extent_q  <= '0;
      scale_q   <= '0;
      idx_q     <= '0;
      ak_q      <= '0;
      cm_q      <= '0;
      found_q   <= 1'b0;
      div_pos_q <= 1'b0;
    end else begin
      if (cfg_valid_i) bins_q <= cfg_data_i;
      if (cmd_i.ld_begin) begin
        axis_q   <= axis_d;
        origin_q <= origin_d;
        extent_q <= (sz_sel > 0) ? sz_sel[31:0] : '0;
        scale_q  <= '0;
        idx_q    <= '0;
      end
      if (div_start) div_pos_q <= cmd_i.pos_start;
      if (div_done && !div_pos_q) begin
        scale_q <= (div_quo[DIV_NW-1:32] != '0) ? '1 : div_quo[31:0];
      end
      if (cmd_i.clr_wr) idx_q <= idx_q + IW'(1);
      if (cmd_i.fin_init) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.pfx_wr && idx_q != nm2) idx_q <= idx_q + IW'(1);
      if (cmd_i.scan_grow) ak_q <= '0;
      if (cmd_i.area_step) begin
        ak_q <= ak_q + 3'd1;
        cm_q <= '0;
      end
      if (cmd_i.cmul_step) cm_q <= cm_q + CMW'(1);
      if (cmd_i.eval) begin
        if (cost_ok) found_q <= 1'b1;
        if (idx_q != '0) idx_q <= idx_q - IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
    if (cmd_i.ld_tri) tri_q <= in_data_i;
    if (cmd_i.tri_rd) tri_idx_q <= tri_idx;
    if (cmd_i.fin_init) begin
      acc_q      <= EMPTY_BOX;
      racc_q     <= EMPTY_BOX;
      lcnt_q     <= '0;
      nr_q       <= '0;
      best_q     <= COST_TOP;
      best_l_q   <= '0;
      best_r_q   <= '0;
      pos_q      <= '0;
      best_idx_q <= '0;
    end
    if (cmd_i.pfx_wr) begin
      acc_q  <= acc_next;
      lcnt_q <= lcnt_next;
    end
    if (cmd_i.scan_grow) begin
      racc_q  <= box_grow(racc_q, brd_q.bx);
      nr_q    <= nr_q + CW'(brd_q.cnt);
      lbox_q  <= prd_q.bx;
      ml_q    <= prd_q.cnt;
      sum_l_q <= '0;
      sum_r_q <= '0;
    end
    if (cmd_i.area_step) begin
      // The product of step k is registered, so step k adds term k-1.
      if (ak_q >= 3'd1 && ak_q <= 3'd3) sum_l_q <= sum_l_q + (AREA_W - 1)'(prod_q[63:16]);
      if (ak_q >= 3'd4) sum_r_q <= sum_r_q + (AREA_W - 1)'(prod_q[63:16]);
      acc_l_q <= '0;
      acc_r_q <= '0;
      mr_q    <= nr_q;
    end
    if (cmd_i.cmul_step) begin
      acc_l_q <= (acc_l_q << 1) + (ml_q[CW-1] ? PW'(area_l) : '0);
      acc_r_q <= (acc_r_q << 1) + (mr_q[CW-1] ? PW'(area_r) : '0);
      ml_q    <= ml_q << 1;
      mr_q    <= mr_q << 1;
    end
    if (cmd_i.eval && cost_ok) begin
      best_q     <= cost;
      best_l_q   <= lbox_q;
      best_r_q   <= racc_q;
      best_idx_q <= idx_q;
    end
    if (div_done && div_pos_q) pos_q <= origin_q + div_quo[31:0];
  end

  assign st_o.idx_top   = idx_q == nm2;
  assign st_o.idx_zero  = idx_q == '0;
  assign st_o.clr_last  = idx_q == IW'(MAX_BINS - 1);
  assign st_o.area_last = ak_q == 3'd6;
  assign st_o.cmul_last = cm_q == CMW'(CW - 1);
  assign st_o.div_busy  = div_busy;
  assign st_o.div_done  = div_done;
  assign st_o.found     = found_q;

  box_t out_box;
  assign out_box = cmd_i.out_side ? best_r_q : best_l_q;

  always_comb begin
    out_data_o.found          = found_q;
    out_data_o.split_axis     = axis_q;
    out_data_o.split_position = pos_q;
    out_data_o.best_cost      = best_q;
    out_data_o.side           = cmd_i.out_side;
    out_data_o.box_min_x      = out_box.lo[0];
    out_data_o.box_min_y      = out_box.lo[1];
    out_data_o.box_min_z      = out_box.lo[2];
    out_data_o.box_max_x      = out_box.hi[0];
    out_data_o.box_max_y      = out_box.hi[1];
    out_data_o.box_max_z      = out_box.hi[2];
    out_data_o.last           = cmd_i.out_side;
  end

endmodule

// File: hdl/binned_sah_split_finder.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_data_i  (in_item_t)
// out       output     out_valid_o / out_ready_i out_data_o (out_item_t)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (bin count)
//
// One transaction is in work at a time; in_ready_o is high only while idle.
// Triangle: the multiply, then the bin read-modify-write (read state, write state).
// Begin: the scale divide, with the sweep that clears all MAX_BINS bins running
// alongside; a zero extent skips the divide and waits only for the sweep.
// Finish: a prefix pass over the n bins, then a scan of the planes with the area
// sums and the serial cost multiply, the position divide when a split is found,
// then the output with its stalls; the serial cost multiply dominates.
// After reset the block sweeps all MAX_BINS bins empty before taking input.

module binned_sah_split_finder
  import bss_pkg::*;
#(
  parameter int MAX_BINS   = 32,
  parameter int COUNT_BITS = 21
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready_o = 1'b1;

  bss_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .st_i       (st)
  );

  bss_datapath #(
    .MAX_BINS  (MAX_BINS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_data_o (out_data_o)
  );

endmodule
